@@ sv/gspea_pkg.sv @@
// Shared types and constants for the GPS subframe parity / ephemeris assembler.
// No dependencies; imported by gspea_parity_unit and the top level.
`default_nettype none

package gspea_pkg;

  // Word layout and subframe geometry
  localparam int NUM_MASKS = 6;
  localparam int WORD_W    = 32;
  localparam int DATA_W    = 24;
  localparam int NUM_WORDS = 10;
  localparam int LAST_WORD = 9;
  localparam int NUM_SF    = 3;
  localparam int NUM_PAIRS = 5;
  localparam int LAST_POS  = 44;
  localparam int CFG_IDX_W = 3;

  // Parity mask registers, element i drives parity bit D(25+i)
  typedef logic [NUM_MASKS-1:0][WORD_W-1:0] mask_arr_t;

  localparam mask_arr_t MASK_RESET = {
    32'd2340063680,  // D30
    32'd1806824256,  // D29
    32'd1466164864,  // D28
    32'd2932329728,  // D27
    32'd1569692224,  // D26
    32'd3139384448   // D25
  };

  // Result status codes
  typedef enum logic [1:0] {
    ST_STORED      = 2'd0,
    ST_NOT_WANTED  = 2'd1,
    ST_PARITY_ERR  = 2'd2,
    ST_BAD_CHANNEL = 2'd3
  } status_t;

  // Result item kinds
  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EPH    = 1'b1
  } kind_t;

  // Request to and answer from the parity unit
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] word;
  } par_req_t;

  typedef struct packed {
    logic done;
    logic good;
  } par_res_t;

endpackage

`default_nettype wire

@@ sv/gps_subframe_parity_ephemeris_assembler_top.sv @@
// Top level: word sequencer, staging registers, per-channel subframe store and output register.
// Depends on gspea_pkg and gspea_parity_unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall  | rx_channel, sat_number, word_index, nav_word
//  out     | output    | out_valid/out_stall| kind, status, word_pos, packed_data, last
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata (parity masks 0..5)
//
// Words 0 to 8 pass through capture, six steps of the shared parity unit and write-back.
// Word 9 adds a copy of the ten staged words into the store, three lookups and then either a
// status transfer or, per packed triple, two store reads and three transfers, 45 words in all.
// The single-port reads of the subframe store set the emission rate.
// Reset is synchronous; the store needs no clearing pass, slot valid flags clear at once.
// in_stall is high in reset and from acceptance until write-back, for word 9 until its last result is loaded;
// out_stall only holds the output register and the sequencer behind it.
`default_nettype none

module gps_subframe_parity_ephemeris_assembler_top #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_channel,
  input  logic [7:0]                     in_sat_number,
  input  logic [3:0]                     in_word_index,
  input  logic [31:0]                    in_nav_word,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [1:0]                     out_status,
  output logic [5:0]                     out_word_pos,
  output logic [15:0]                    out_packed_data,
  output logic                           out_last,
  // configuration
  input  logic                           cfg_we,
  input  logic [gspea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import gspea_pkg::*;

  localparam int NSLOTS      = NUM_CHANNELS * NUM_SF;
  localparam int STORE_DEPTH = NSLOTS * NUM_WORDS;
  localparam int SW          = $clog2(NSLOTS);
  localparam int AW          = $clog2(STORE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_PSTART, S_PWAIT, S_CHECK, S_COPY, S_LISS, S_LCAP, S_DECIDE,
    S_STAT, S_RDA, S_RDB, S_CAP, S_EOUT
  } state_t;

  // slot number of subframe s on channel ch
  function automatic logic [SW-1:0] slot_idx(input logic [7:0] ch, input logic [1:0] s);
    return SW'(32'(ch) * 32'd3 + 32'(s));
  endfunction

  // store address of word w of a slot
  function automatic logic [AW-1:0] st_addr(input logic [SW-1:0] slot, input logic [3:0] w);
    return AW'(32'(slot) * 32'd10 + 32'(w));
  endfunction

  // words holding IODC / IODE in subframes 1, 2, 3
  function automatic logic [3:0] look_word(input logic [1:0] rc);
    logic [3:0] w;
    unique case (rc)
      2'd0:    w = 4'd7;
      2'd1:    w = 4'd2;
      default: w = 4'd9;
    endcase
    return w;
  endfunction

  state_t                         state_r;
  mask_arr_t                      mask_r;

  // captured input item
  logic [7:0]                     ch_r;
  logic [7:0]                     sat_in_r;
  logic [3:0]                     idx_r;
  logic [WORD_W-1:0]              word_r;

  // staging and slot bookkeeping
  logic [NUM_WORDS-1:0][DATA_W-1:0] staging_r;
  logic                           parity_ok_r;
  logic [NSLOTS-1:0]              slot_valid_r;
  logic [1:0]                     slot_sel_r;
  logic [3:0]                     cj_r;
  logic [1:0]                     rc_r;
  logic [2:0][7:0]                iodc_r;
  logic [2:0][7:0]                satv_r;
  status_t                        stat_code_r;

  // emission counters and operands
  logic [1:0]                     ei_r;
  logic [2:0]                     ej_r;
  logic [1:0]                     en_r;
  logic [5:0]                     pos_r;
  logic [DATA_W-1:0]              a_r;
  logic [DATA_W-1:0]              b_r;

  // output register
  logic                           out_valid_r;
  logic                           out_kind_r;
  logic [1:0]                     out_status_r;
  logic [5:0]                     out_word_pos_r;
  logic [15:0]                    out_packed_data_r;
  logic                           out_last_r;

  // memories
  logic [DATA_W-1:0]              store_mem [STORE_DEPTH];
  logic [DATA_W-1:0]              store_rdata_r;
  logic [7:0]                     sat_mem [NSLOTS];
  logic [7:0]                     sat_rdata_r;

  // combinational helpers
  par_req_t                       par_req;
  par_res_t                       par_res;
  logic [DATA_W-1:0]              strip_c;
  logic [2:0]                     sf_c;
  logic [1:0]                     sub_c;
  logic                           out_free;
  logic                           in_xfer;
  logic                           match_c;
  logic [SW-1:0]                  rd_slot;
  logic [3:0]                     rd_word;
  logic [AW-1:0]                  rd_addr;
  logic                           st_we;
  logic [AW-1:0]                  st_waddr;
  logic [SW-1:0]                  s0_c;
  logic [SW-1:0]                  s1_c;
  logic [SW-1:0]                  s2_c;
  logic [15:0]                    d_c;

  gspea_parity_unit u_parity (
    .clk   (clk),
    .rst_n (rst_n),
    .mask  (mask_r),
    .req   (par_req),
    .res   (par_res)
  );

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign par_req = '{start: (state_r == S_PSTART), word: word_r};

  // strip to 24 data bits, inverted under D30*
  assign strip_c = word_r[30] ? ~word_r[29:6] : word_r[29:6];
  assign sf_c    = staging_r[1][4:2];
  assign sub_c   = sf_c[1:0] - 2'd1;

  assign s0_c = slot_idx(ch_r, 2'd0);
  assign s1_c = slot_idx(ch_r, 2'd1);
  assign s2_c = slot_idx(ch_r, 2'd2);

  // full matching set on this channel
  assign match_c = slot_valid_r[s0_c] && slot_valid_r[s1_c] && slot_valid_r[s2_c] &&
                   (satv_r[0] == satv_r[1]) && (satv_r[0] == satv_r[2]) &&
                   (iodc_r[0] == iodc_r[1]) && (iodc_r[0] == iodc_r[2]);

  // store read address
  always_comb begin
    rd_slot = s0_c;
    rd_word = '0;
    unique case (state_r)
      S_LISS: begin
        rd_slot = slot_idx(ch_r, rc_r);
        rd_word = look_word(rc_r);
      end
      S_RDA: begin
        rd_slot = slot_idx(ch_r, ei_r);
        rd_word = {ej_r, 1'b0};
      end
      S_RDB: begin
        rd_slot = slot_idx(ch_r, ei_r);
        rd_word = {ej_r, 1'b1};
      end
      default: begin
        rd_slot = s0_c;
        rd_word = '0;
      end
    endcase
  end

  assign rd_addr  = st_addr(rd_slot, rd_word);
  assign st_we    = (state_r == S_COPY);
  assign st_waddr = st_addr(slot_idx(ch_r, slot_sel_r), cj_r);

  // packed word for the current triple position
  always_comb begin
    unique case (en_r)
      2'd0:    d_c = (ej_r == 3'd0) ? {8'd0, sat_in_r} : a_r[23:8];
      2'd1:    d_c = (ej_r == 3'd0) ? {8'd0, b_r[23:16]} : {a_r[7:0], b_r[23:16]};
      default: d_c = b_r[15:0];
    endcase
  end

  // subframe store: one write, one registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= staging_r[cj_r];
    end
    store_rdata_r <= store_mem[rd_addr];
  end

  // satellite number per slot
  always_ff @(posedge clk) begin
    if ((state_r == S_CHECK) && (32'(ch_r) < NUM_CHANNELS) && parity_ok_r &&
        (sf_c >= 3'd1) && (sf_c <= 3'd3)) begin
      sat_mem[slot_idx(ch_r, sub_c)] <= sat_in_r;
    end
    sat_rdata_r <= sat_mem[rd_slot];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_MASKS))) begin
      mask_r[cfg_index] <= cfg_wdata;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      parity_ok_r  <= 1'b1;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            ch_r     <= in_rx_channel;
            sat_in_r <= in_sat_number;
            idx_r    <= in_word_index;
            word_r   <= in_nav_word;
            if (in_word_index <= 4'(LAST_WORD)) begin
              state_r <= S_PSTART;
            end
          end
        end
        S_PSTART: begin
          state_r <= S_PWAIT;
        end
        S_PWAIT: begin
          if (par_res.done) begin
            staging_r[idx_r] <= strip_c;
            parity_ok_r      <= (idx_r == 4'd0) ? par_res.good : (parity_ok_r && par_res.good);
            state_r          <= (idx_r == 4'(LAST_WORD)) ? S_CHECK : S_IDLE;
          end
        end
        // word 9: checks in priority order
        S_CHECK: begin
          priority if (32'(ch_r) >= NUM_CHANNELS) begin
            stat_code_r <= ST_BAD_CHANNEL;
            state_r     <= S_STAT;
          end else if (!parity_ok_r) begin
            stat_code_r <= ST_PARITY_ERR;
            state_r     <= S_STAT;
          end else if ((sf_c < 3'd1) || (sf_c > 3'd3)) begin
            stat_code_r <= ST_NOT_WANTED;
            state_r     <= S_STAT;
          end else begin
            slot_sel_r                       <= sub_c;
            slot_valid_r[slot_idx(ch_r, sub_c)] <= 1'b1;
            cj_r                             <= '0;
            state_r                          <= S_COPY;
          end
        end
        S_COPY: begin
          if (cj_r == 4'(LAST_WORD)) begin
            rc_r    <= '0;
            state_r <= S_LISS;
          end else begin
            cj_r <= cj_r + 4'd1;
          end
        end
        S_LISS: begin
          state_r <= S_LCAP;
        end
        S_LCAP: begin
          iodc_r[rc_r] <= store_rdata_r[23:16];
          satv_r[rc_r] <= sat_rdata_r;
          if (rc_r == 2'(NUM_SF - 1)) begin
            state_r <= S_DECIDE;
          end else begin
            rc_r    <= rc_r + 2'd1;
            state_r <= S_LISS;
          end
        end
        S_DECIDE: begin
          if (match_c) begin
            ei_r    <= '0;
            ej_r    <= '0;
            en_r    <= '0;
            pos_r   <= '0;
            state_r <= S_RDA;
          end else begin
            stat_code_r <= ST_STORED;
            state_r     <= S_STAT;
          end
        end
        S_STAT: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_kind_r        <= KIND_STATUS;
            out_status_r      <= stat_code_r;
            out_word_pos_r    <= '0;
            out_packed_data_r <= '0;
            out_last_r        <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_RDA: begin
          state_r <= S_RDB;
        end
        S_RDB: begin
          a_r     <= store_rdata_r;
          state_r <= S_CAP;
        end
        S_CAP: begin
          b_r     <= store_rdata_r;
          state_r <= S_EOUT;
        end
        // one packed word per output transfer
        S_EOUT: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_kind_r        <= KIND_EPH;
            out_status_r      <= ST_STORED;
            out_word_pos_r    <= pos_r;
            out_packed_data_r <= d_c;
            out_last_r        <= (pos_r == 6'(LAST_POS));
            pos_r             <= pos_r + 6'd1;
            if (en_r == 2'd2) begin
              en_r <= '0;
              if (ej_r == 3'(NUM_PAIRS - 1)) begin
                slot_valid_r[slot_idx(ch_r, ei_r)] <= 1'b0;
                ej_r <= '0;
                if (ei_r == 2'(NUM_SF - 1)) begin
                  state_r <= S_IDLE;
                end else begin
                  ei_r    <= ei_r + 2'd1;
                  state_r <= S_RDA;
                end
              end else begin
                ej_r    <= ej_r + 3'd1;
                state_r <= S_RDA;
              end
            end else begin
              en_r <= en_r + 2'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_word_pos    = out_word_pos_r;
  assign out_packed_data = out_packed_data_r;
  assign out_last        = out_last_r;

`ifndef SYNTH
  // final ephemeris word sits at the last packed position
  a_eph_last_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_EPH) && out_last) |-> (out_word_pos == 6'(LAST_POS)))
    else $error("ephemeris run closed at wrong position");

  // status items are single, empty results
  a_status_shape : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_STATUS)) |->
      (out_last && (out_word_pos == 6'd0) && (out_packed_data == 16'd0)))
    else $error("malformed status item");

  // an out-of-range word index is dropped without holding the input
  a_skip_index : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_word_index > 4'(LAST_WORD))) |=> !in_stall)
    else $error("ignored word stalled the input");

  // packed words are only loaded by the emission sequencer
  a_eph_source : assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && (out_kind == KIND_EPH)) |-> ($past(state_r) == S_EOUT))
    else $error("ephemeris word outside emission");
`endif

endmodule

`default_nettype wire

@@ sv/gspea_parity_unit.sv @@
// Iterative parity checker: one mask AND / XOR-reduce per cycle while busy, one step per mask.
// Depends on gspea_pkg for the mask array and request/answer structs.
`default_nettype none

module gspea_parity_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gspea_pkg::mask_arr_t mask,
  input  gspea_pkg::par_req_t  req,
  output gspea_pkg::par_res_t  res
);
  import gspea_pkg::*;

  logic              busy_r;
  logic [2:0]        cnt_r;
  logic [WORD_W-1:0] chk_r;
  logic [5:0]        ref_r;
  logic [5:0]        par_r;
  logic              done_r;
  logic              good_r;

  logic              bit_c;
  logic [5:0]        par_c;

  // Shared reduce unit: parity bit for the mask picked by the step counter
  always_comb begin
    bit_c = ^(mask[cnt_r] & chk_r);
    par_c = par_r;
    par_c[3'd5 - cnt_r] = bit_c;
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        par_r  <= '0;
        ref_r  <= req.word[5:0];
        // D30* set: data bits are checked inverted, parity bits are compared as received
        chk_r  <= req.word[30] ? {req.word[31:30], ~req.word[29:0]} : req.word;
      end else if (busy_r) begin
        par_r <= par_c;
        if (cnt_r == 3'(NUM_MASKS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          good_r <= (par_c == ref_r);
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign res = '{done: done_r, good: good_r};

endmodule

`default_nettype wire
